FILE: src/lqrsf_pkg.sv
// Shared types, constants and gain/reference/trim tables for the LQR state-feedback block.
package lqrsf_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_DRIVES  = 6;
    localparam int IDX_W       = 4;
    localparam int DRV_W       = 3;
    localparam int VAL_W       = 32;
    localparam int ACC_W       = 64;
    localparam int ROUND_SHIFT = 24;
    localparam int Q_W         = ACC_W - ROUND_SHIFT + 1;
    localparam int DRV_ADDR_W  = $clog2(NUM_DRIVES);

    localparam logic [DRV_ADDR_W-1:0] DRV_LAST = DRV_ADDR_W'(NUM_DRIVES - 1);
    localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(NUM_STATES - 1);

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_RND,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic                  rd_en;
        logic [DRV_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [DRV_ADDR_W-1:0] wr_addr;
    } mem_req_t;

    typedef struct packed {
        logic             capture;
        logic             round_en;
        logic             load;
        logic             last;
        logic [DRV_W-1:0] index;
    } out_ctl_t;

    localparam val_t GAIN_ROM [NUM_DRIVES][NUM_STATES] = '{
        '{ -45911, 122498843, 122522331, -447414796, -335075, 1881733, -10431234, 9618546,
           -64096, 133704345, 101124669, -74958923, -94585, 1110635, 394416, -466440 },
        '{ -50374, -122498843, 122524008, 447414796, -302225, -1881733, 9711995, -10338456,
           -65045, -133702667, 101126347, 74958923, -75318, -1110551, -457917, 402821 },
        '{ 593158, -11935, 233, 94298, 4051194, 453052, 6768264, 1166688,
           804233, -17121, 196, 30447, 1117631, 422450, 714391, 24530 },
        '{ 593158, 11914, 233, -93934, 4051194, -453052, 1166771, 6768264,
           804233, 17072, 196, -30326, 1117614, -422450, 24533, 714391 },
        '{ 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0 },
        '{ 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0 }
    };

    localparam val_t XREF_ROM [NUM_STATES] = '{
        0, 0, 65536, 9, -12845, 0, 12845, 12845, 0, 0, 0, 0, 0, 0, 0, 0
    };

    localparam val_t UR_ROM [NUM_DRIVES] = '{ 541983, 540017, 5, 4, 0, 0 };

endpackage

FILE: src/lqr_state_feedback.sv
// Top level of the LQR state-feedback regulator: control sequencer and multiply-accumulate.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+---------------------------------------
//   state     | in        | state_valid / state_stall | state_index, state_value
//   drive     | out       | drive_valid / drive_stall | drive_index, drive_value, last_drive
//
// A state element passes through latching the error, priming the accumulator memory read, and
// then, for each drive in turn, the shared multiplier and a read-modify-write of the
// one-read one-write accumulator memory.
// For the element with the last index each drive goes through read, accumulate, round and load
// output in turn, back to idle after the last drive; load waits while drive_stall holds the output register.
// Reset clears all accumulators at once through per-entry valid bits; no clearing pass.
module lqr_state_feedback (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               state_valid,
    output logic                               state_stall,
    input  logic [lqrsf_pkg::IDX_W-1:0]        state_index,
    input  logic signed [lqrsf_pkg::VAL_W-1:0] state_value,
    output logic                               drive_valid,
    input  logic                               drive_stall,
    output logic [lqrsf_pkg::DRV_W-1:0]        drive_index,
    output logic signed [lqrsf_pkg::VAL_W-1:0] drive_value,
    output logic                               last_drive
);
    import lqrsf_pkg::*;

    fsm_t                  state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg;
    logic                  emit_reg, emit_next;
    val_t                  err_reg, err_next;
    logic [DRV_ADDR_W-1:0] d_reg, d_next;
    acc_t                  prod_reg;
    acc_t                  prod_next;
    logic signed [VAL_W:0] diff;
    mem_req_t              mem_req;
    acc_t                  wr_data;
    acc_t                  rd_data;
    logic signed [ACC_W:0] sum_full;
    acc_t                  sum_sat;
    out_ctl_t              out_ctl;
    logic                  out_free;
    logic                  in_take;

    assign in_take = state_valid && !state_stall;
    assign state_stall = (state_reg != S_IDLE);

    assign diff = (VAL_W+1)'(state_value) - (VAL_W+1)'(XREF_ROM[state_index]);

    always_comb
    begin
        if (diff[VAL_W] != diff[VAL_W-1])
        begin
            err_next = diff[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            err_next = diff[VAL_W-1:0];
        end
    end

    assign prod_next = err_reg * GAIN_ROM[mem_req.rd_addr][idx_reg];

    assign sum_full = (ACC_W+1)'(rd_data) + (ACC_W+1)'(prod_reg);

    always_comb
    begin
        if (sum_full[ACC_W] != sum_full[ACC_W-1])
        begin
            sum_sat = sum_full[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_full[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            d_reg     <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            d_reg     <= d_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            idx_reg <= state_index;
            err_reg <= err_next;
        end
        if (mem_req.rd_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        d_next          = d_reg;
        emit_next       = emit_reg;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = d_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = d_reg;
        wr_data         = sum_sat;
        out_ctl.capture  = 1'b0;
        out_ctl.round_en = 1'b0;
        out_ctl.load     = 1'b0;
        out_ctl.last     = (d_reg == DRV_LAST);
        out_ctl.index    = DRV_W'(d_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take && ({1'b0, state_index} < (IDX_W+1)'(NUM_STATES)))
                begin
                    emit_next  = (state_index == IDX_LAST);
                    d_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mem_req.rd_en = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                mem_req.wr_en = 1'b1;
                if (emit_reg)
                begin
                    wr_data         = '0;
                    out_ctl.capture = 1'b1;
                    state_next      = S_RND;
                end
                else if (d_reg == DRV_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = d_reg + 1'b1;
                    d_next          = d_reg + 1'b1;
                end
            end
            S_RND:
            begin
                out_ctl.round_en = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_ctl.load = 1'b1;
                    if (d_reg == DRV_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    lqrsf_acc_mem u_acc_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    lqrsf_drive_out u_drive_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (out_ctl),
        .sum         (sum_sat),
        .out_free    (out_free),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_index (drive_index),
        .drive_value (drive_value),
        .last_drive  (last_drive)
    );

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
        else $error("accumulator read and write hit the same entry");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> last_drive == (drive_index == DRV_W'(DRV_LAST)))
        else $error("last_drive does not match the final drive index");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && ({1'b0, state_index} < (IDX_W+1)'(NUM_STATES)) |=> state_stall)
        else $error("no busy after accepting a state element");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.load |-> out_free)
        else $error("output register overwritten while held");

endmodule

FILE: src/lqrsf_acc_mem.sv
// Drive accumulator memory with registered read and per-entry valid bits.
module lqrsf_acc_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  lqrsf_pkg::mem_req_t req,
    input  lqrsf_pkg::acc_t     wr_data,
    output lqrsf_pkg::acc_t     rd_data
);
    import lqrsf_pkg::*;

    acc_t                  mem [NUM_DRIVES];
    logic [NUM_DRIVES-1:0] valid_reg;
    acc_t                  rd_data_reg;
    logic                  rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

FILE: src/lqrsf_drive_out.sv
// Drive rounding, trim subtraction, saturation and output register.
module lqrsf_drive_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lqrsf_pkg::out_ctl_t               ctl,
    input  lqrsf_pkg::acc_t                   sum,
    output logic                              out_free,
    output logic                              drive_valid,
    input  logic                              drive_stall,
    output logic [lqrsf_pkg::DRV_W-1:0]       drive_index,
    output logic signed [lqrsf_pkg::VAL_W-1:0] drive_value,
    output logic                              last_drive
);
    import lqrsf_pkg::*;

    acc_t                    sum_reg;
    logic signed [Q_W-1:0]   q_reg;
    logic signed [Q_W-1:0]   q_next;
    logic signed [Q_W:0]     u_full;
    val_t                    u_sat;
    logic [DRV_ADDR_W-1:0]   ur_addr;
    logic                    valid_reg;
    logic [DRV_W-1:0]        index_reg;
    val_t                    value_reg;
    logic                    last_reg;

    assign q_next = Q_W'(sum_reg >>> ROUND_SHIFT) + Q_W'(sum_reg[ROUND_SHIFT-1]);

    assign ur_addr = ctl.index[DRV_ADDR_W-1:0];

    always_comb
    begin
        u_full = (Q_W+1)'(UR_ROM[ur_addr]) - (Q_W+1)'(q_reg);
        if (u_full > (Q_W+1)'(signed'({1'b0, {(VAL_W-1){1'b1}}})))
        begin
            u_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (u_full < -(Q_W+1)'(signed'({1'b0, 1'b1, {(VAL_W-1){1'b0}}})))
        begin
            u_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            u_sat = u_full[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            sum_reg <= sum;
        end
        if (ctl.round_en)
        begin
            q_reg <= q_next;
        end
        if (ctl.load)
        begin
            index_reg <= ctl.index;
            value_reg <= u_sat;
            last_reg  <= ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!drive_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_free    = !valid_reg || !drive_stall;
    assign drive_valid = valid_reg;
    assign drive_index = index_reg;
    assign drive_value = value_reg;
    assign last_drive  = last_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for lqr_state_feedback: random and directed state vectors against a predictor.
module tb_top;
    import lqrsf_pkg::*;

    localparam int WIDE_W     = ACC_W + 2;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_MAX  = 3000;
    localparam int TAIL_WAIT  = 40;
    localparam int PRINT_MAX  = 50;

    localparam logic signed [WIDE_W-1:0] ONE_W      = 1;
    localparam logic signed [WIDE_W-1:0] ACC_HI     = (ONE_W <<< (ACC_W - 1)) - ONE_W;
    localparam logic signed [WIDE_W-1:0] ACC_LO     = -(ONE_W <<< (ACC_W - 1));
    localparam logic signed [WIDE_W-1:0] VAL_HI     = (ONE_W <<< (VAL_W - 1)) - ONE_W;
    localparam logic signed [WIDE_W-1:0] VAL_LO     = -(ONE_W <<< (VAL_W - 1));
    localparam logic signed [WIDE_W-1:0] ROUND_HALF = ONE_W <<< (ROUND_SHIFT - 1);

    localparam val_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam val_t VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic [DRV_W-1:0] index;
        val_t             value;
        logic             is_last;
    } drive_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             state_valid = 1'b0;
    logic             state_stall;
    logic [IDX_W-1:0] state_index = '0;
    val_t             state_value = '0;
    logic             drive_valid;
    logic             drive_stall = 1'b0;
    logic [DRV_W-1:0] drive_index;
    val_t             drive_value;
    logic             last_drive;

    acc_t   drive_acc_sum [NUM_DRIVES] = '{default: '0};
    drive_t pending_drives [$];

    bit sender_gaps   = 1'b1;
    bit receiver_gaps = 1'b1;
    bit long_hold_req = 1'b0;

    int error_count    = 0;
    int states_taken   = 0;
    int drives_checked = 0;
    int vectors_seen   = 0;

    lqr_state_feedback DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .state_valid (state_valid),
        .state_stall (state_stall),
        .state_index (state_index),
        .state_value (state_value),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_index (drive_index),
        .drive_value (drive_value),
        .last_drive  (last_drive)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("** lqr_state_feedback: FAILED **");
        $finish;
    end

    function automatic val_t clip_to_val(input logic signed [WIDE_W-1:0] v);
        if (v > VAL_HI)
            return VAL_MAX;
        if (v < VAL_LO)
            return VAL_MIN;
        return val_t'(v);
    endfunction

    function automatic val_t pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3, 4: return val_t'($urandom);
            default: return val_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= PRINT_MAX)
            $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic apply_state_element(input logic [IDX_W-1:0] idx, input val_t x);
        logic signed [WIDE_W-1:0] sum;
        logic signed [WIDE_W-1:0] rounded;
        val_t                     err;
        drive_t                   res;
        err = clip_to_val(WIDE_W'(x) - WIDE_W'(XREF_ROM[idx]));
        for (int d = 0; d < NUM_DRIVES; d++)
        begin
            sum = WIDE_W'(drive_acc_sum[d]) + WIDE_W'(err) * WIDE_W'(GAIN_ROM[d][idx]);
            if (sum > ACC_HI)
                sum = ACC_HI;
            else if (sum < ACC_LO)
                sum = ACC_LO;
            drive_acc_sum[d] = acc_t'(sum);
        end
        if (idx == IDX_LAST)
        begin
            for (int d = 0; d < NUM_DRIVES; d++)
            begin
                rounded     = (WIDE_W'(drive_acc_sum[d]) + ROUND_HALF) >>> ROUND_SHIFT;
                res.index   = DRV_W'(d);
                res.value   = clip_to_val(WIDE_W'(UR_ROM[d]) - rounded);
                res.is_last = (d == NUM_DRIVES - 1);
                pending_drives.push_back(res);
                drive_acc_sum[d] = '0;
            end
            vectors_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && state_valid && !state_stall)
        begin
            states_taken++;
            apply_state_element(state_index, state_value);
        end
    end

    always @(posedge clk)
    begin : drive_check
        drive_t want;
        if (rst_n && drive_valid && !drive_stall)
        begin
            drives_checked++;
            if (pending_drives.size() == 0)
                report_mismatch("drive transaction with none expected", drive_index, -1);
            else
            begin
                want = pending_drives.pop_front();
                if (drive_index !== want.index)
                    report_mismatch("drive_index", drive_index, want.index);
                if (drive_value !== want.value)
                    report_mismatch($sformatf("drive_value of drive %0d", want.index),
                                    longint'(drive_value), longint'(want.value));
                if (last_drive !== want.is_last)
                    report_mismatch($sformatf("last_drive of drive %0d", want.index),
                                    last_drive, want.is_last);
            end
        end
    end

    initial
    begin : drive_sink
        int wait_n;
        forever
        begin
            wait_n = receiver_gaps ? $urandom_range(0, 15) : 0;
            if (long_hold_req)
            begin
                wait_n        = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (wait_n > 0)
            begin
                drive_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            drive_stall <= 1'b0;
            do
                @(posedge clk);
            while (!drive_valid);
        end
    end

    task automatic send_state_element(input logic [IDX_W-1:0] idx, input val_t x);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            state_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        state_valid <= 1'b1;
        state_index <= idx;
        state_value <= x;
        do
            @(posedge clk);
        while (state_stall);
    endtask

    task automatic send_full_vector();
        for (int i = 0; i < NUM_STATES; i++)
            send_state_element(IDX_W'(i), pick_value());
    endtask

    task automatic drain_pending();
        int waited;
        waited = 0;
        state_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_drives.size() != 0 && waited < DRAIN_MAX);
    endtask

    task automatic test_directed();
        send_state_element(IDX_LAST, '0);
        send_state_element(4'd0, VAL_MAX);
        send_state_element(IDX_LAST, VAL_MIN);
        send_state_element(4'd2, VAL_MIN);
        send_state_element(4'd4, VAL_MAX);
        send_state_element(IDX_LAST, VAL_MAX);
        send_state_element(4'd7, XREF_ROM[7]);
        send_state_element(4'd2, XREF_ROM[2]);
        send_state_element(IDX_LAST, '0);
        repeat (10) send_state_element(4'd3, VAL_MAX);
        send_state_element(IDX_LAST, '0);
        repeat (3) send_state_element(4'd3, VAL_MIN);
        send_state_element(IDX_LAST, 32'sh0000_FFFF);
    endtask

    task automatic test_random_vectors();
        repeat (18) send_full_vector();
    endtask

    task automatic test_noise();
        repeat (80)
        begin
            if ($urandom_range(0, 3) == 0)
                send_state_element(IDX_LAST, pick_value());
            else
                send_state_element(IDX_W'($urandom_range(0, NUM_STATES - 1)), pick_value());
        end
    endtask

    task automatic test_back_pressure();
        sender_gaps   = 1'b0;
        long_hold_req = 1'b1;
        repeat (3) send_full_vector();
        sender_gaps   = 1'b1;
    endtask

    task automatic test_no_idle();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        repeat (5) send_full_vector();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial
    begin : run
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain_pending();
        test_random_vectors();
        drain_pending();
        test_noise();
        drain_pending();
        test_back_pressure();
        drain_pending();
        test_no_idle();
        drain_pending();
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_drives.size() != 0)
            report_mismatch("drive transactions never produced", 0, pending_drives.size());
        $display("Run covered %0d state transactions and %0d drive transactions (%0d vectors),",
                 states_taken, drives_checked, vectors_seen);
        $display("with saturation corners, broken sequences, long output hold-off and gap-free runs.");
        if (error_count == 0)
            $display("** lqr_state_feedback: PASSED **");
        else
            $display("** lqr_state_feedback: FAILED **");
        $finish;
    end
endmodule
